// ===== hdl/coe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coe_pkg - shared types and constants of the clock offset estimator
// Item kinds, command codes, status codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package coe_pkg;

	// input item kinds
	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_TIMEOUT = 2'd1;
	localparam logic [1:0] KIND_REPLY   = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_DOWN   = 2'd0;
	localparam logic [1:0] STAT_GOOD   = 2'd1;
	localparam logic [1:0] STAT_NONSTD = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_REPLIES = 2'd0;
	localparam logic [1:0] REG_MAX_TRIALS  = 2'd1;
	localparam logic [1:0] REG_RANGE_MS    = 2'd2;
	localparam logic [1:0] REG_PROC_MS     = 2'd3;

	// register reset values
	localparam logic [7:0]  MAX_REPLIES_RST = 8'd10;
	localparam logic [7:0]  MAX_TRIALS_RST  = 8'd20;
	localparam logic [15:0] RANGE_MS_RST    = 16'd20;
	localparam logic [7:0]  PROC_MS_RST     = 8'd5;

	// 12-hour fold window
	localparam logic signed [31:0] FOLD_HI = 32'sd43199999;
	localparam logic signed [31:0] FOLD_LO = -32'sd43200000;
	localparam logic [31:0]        DAY_MS  = 32'd86400000;
	localparam logic [31:0]        MIN_INIT = 32'h7fff_ffff;

	// queue depths
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 4;

	// classified command from front to back
	typedef enum logic [1:0] {
		OP_START,
		OP_TIMEOUT,
		OP_NONSTD,
		OP_REPLY
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        short_rtt;
		logic [31:0] d_out;
		logic [31:0] d_in;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] offset_ms;
	} result_t;

	// limits seen by the back end
	typedef struct packed {
		logic [7:0] max_replies;
		logic [7:0] max_trials;
		logic [7:0] processing_ms;
	} limits_t;

endpackage
`default_nettype wire

// ===== hdl/coe_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coe_front - accepts and classifies input transactions
// Computes round trip checks and raw deltas, folds them into the 12-hour
// window and pushes one command per meaningful transaction.
// ----------------------------------------------------------------------------
module coe_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         kind,
	input  wire logic [26:0]        send_ms,
	input  wire logic [26:0]        recv_ms,
	input  wire logic [31:0]        peer_ms,
	input  wire logic [15:0]        range_ms,
	output logic                    cmd_push,
	output coe_pkg::cmd_t           cmd_data,
	input  wire logic               cmd_full
);

	logic                v_s1;
	coe_pkg::op_t        op_s1;
	logic                short_s1;
	logic [31:0]         raw_out_s1;
	logic [31:0]         raw_in_s1;

	logic                accept;
	logic                load;
	logic [27:0]         rtt;
	logic                rtt_neg;
	logic                rtt_short;
	coe_pkg::op_t        op_nxt;

	function automatic logic [31:0] fold(input logic [31:0] raw);
		logic signed [31:0] d;
		d = $signed(raw);
		if (d < coe_pkg::FOLD_LO)
			fold = raw + coe_pkg::DAY_MS;
		else if (d > coe_pkg::FOLD_HI)
			fold = raw - coe_pkg::DAY_MS;
		else
			fold = raw;
	endfunction

	assign full     = v_s1 && cmd_full;
	assign accept   = push && !full;
	assign cmd_push = v_s1 && !cmd_full;

	assign rtt       = {1'b0, recv_ms} - {1'b0, send_ms};
	assign rtt_neg   = rtt[27];
	assign rtt_short = !rtt_neg && (rtt[26:0] < {11'd0, range_ms});

	// negative round trip behaves exactly like a timeout
	always_comb begin
		op_nxt = coe_pkg::OP_TIMEOUT;
		load   = 1'b1;
		unique case (kind)
			coe_pkg::KIND_START:   op_nxt = coe_pkg::OP_START;
			coe_pkg::KIND_TIMEOUT: op_nxt = coe_pkg::OP_TIMEOUT;
			coe_pkg::KIND_REPLY: begin
				if (rtt_neg)
					op_nxt = coe_pkg::OP_TIMEOUT;
				else if (peer_ms[31])
					op_nxt = coe_pkg::OP_NONSTD;
				else
					op_nxt = coe_pkg::OP_REPLY;
			end
			default: load = 1'b0;   // unused kind is dropped
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept && load) begin
			v_s1 <= 1'b1;
		end else if (cmd_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && load) begin
			op_s1      <= op_nxt;
			short_s1   <= rtt_short;
			raw_out_s1 <= peer_ms - {5'd0, send_ms};
			raw_in_s1  <= {5'd0, recv_ms} - peer_ms;
		end
	end

	assign cmd_data.op        = op_s1;
	assign cmd_data.short_rtt = short_s1;
	assign cmd_data.d_out     = fold(raw_out_s1);
	assign cmd_data.d_in      = fold(raw_in_s1);

endmodule
`default_nettype wire

// ===== hdl/coe_cmd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coe_cmd_queue - short command queue between front and back
// Two entries; lets front and back stall independently.
// ----------------------------------------------------------------------------
module coe_cmd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire coe_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output coe_pkg::cmd_t      pop_data,
	output logic               empty
);

	localparam int PW = $clog2(coe_pkg::CMD_DEPTH);

	coe_pkg::cmd_t         mem [coe_pkg::CMD_DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [PW:0]           count_q;

	assign full     = (count_q == (PW+1)'(coe_pkg::CMD_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/coe_result_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coe_result_fifo - output queue of finished results
// Four entries; the back end reserves space before issuing a run end.
// ----------------------------------------------------------------------------
module coe_result_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire coe_pkg::result_t  push_data,
	input  wire logic              pop,
	output coe_pkg::result_t       pop_data,
	output logic                   empty,
	output logic [$clog2(coe_pkg::RES_DEPTH):0] count
);

	localparam int PW = $clog2(coe_pkg::RES_DEPTH);

	coe_pkg::result_t      mem [coe_pkg::RES_DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [PW:0]           count_q;
	logic                  do_pop;

	assign empty    = (count_q == '0);
	assign count    = count_q;
	assign pop_data = mem[rd_ptr_q];
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/coe_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coe_back - run state and offset computation
// Executes commands against the run state; a run end goes through a
// two-stage finish pipe (minima, difference) into the result queue.
// ----------------------------------------------------------------------------
module coe_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire coe_pkg::limits_t  limits,
	input  wire coe_pkg::cmd_t     cmd,
	input  wire logic              cmd_empty,
	output logic                   cmd_pop,
	input  wire logic [$clog2(coe_pkg::RES_DEPTH):0] res_count,
	output logic                   res_push,
	output coe_pkg::result_t       res_data
);

	localparam int CW = $clog2(coe_pkg::RES_DEPTH) + 1;

	// run state
	logic [31:0]  min_out_q;
	logic [31:0]  min_in_q;
	logic [7:0]   reply_q;
	logic [7:0]   trial_q;
	logic [1:0]   stat_q;
	logic         active_q;

	// finish pipe
	logic         fin_v_s1;
	logic [1:0]   fin_stat_s1;
	logic [31:0]  fin_out_s1;
	logic [31:0]  fin_in_s1;
	logic         fin_v_s2;
	logic [1:0]   fin_stat_s2;
	logic [31:0]  diff_s2;

	logic [31:0]  out_nxt;
	logic [31:0]  in_nxt;
	logic [7:0]   reply_nxt;
	logic [7:0]   trial_nxt;
	logic [1:0]   stat_nxt;
	logic         active_nxt;
	logic         fin_now;
	logic [7:0]   reply_inc;
	logic [7:0]   trial_inc;
	logic         out_less;
	logic         in_less;
	logic [CW-1:0] pending;
	logic         room;
	logic [31:0]  half;

	assign reply_inc = reply_q + 8'd1;
	assign trial_inc = trial_q + 8'd1;
	assign out_less  = $signed(cmd.d_out) < $signed(min_out_q);
	assign in_less   = $signed(cmd.d_in) < $signed(min_in_q);

	always_comb begin
		out_nxt    = min_out_q;
		in_nxt     = min_in_q;
		reply_nxt  = reply_q;
		trial_nxt  = trial_q;
		stat_nxt   = stat_q;
		active_nxt = active_q;
		fin_now    = 1'b0;
		unique case (cmd.op)
			coe_pkg::OP_START: begin
				out_nxt    = coe_pkg::MIN_INIT;
				in_nxt     = coe_pkg::MIN_INIT;
				reply_nxt  = '0;
				trial_nxt  = '0;
				stat_nxt   = coe_pkg::STAT_DOWN;
				active_nxt = 1'b1;
			end
			coe_pkg::OP_TIMEOUT: begin
				if (active_q) begin
					trial_nxt = trial_inc;
					fin_now   = (reply_q >= limits.max_replies) ||
					            (trial_inc >= limits.max_trials);
				end
			end
			coe_pkg::OP_NONSTD: begin
				if (active_q) begin
					reply_nxt = reply_inc;
					stat_nxt  = coe_pkg::STAT_NONSTD;
					fin_now   = 1'b1;
				end
			end
			coe_pkg::OP_REPLY: begin
				if (active_q) begin
					reply_nxt = reply_inc;
					stat_nxt  = coe_pkg::STAT_GOOD;
					// short round trip takes this reply's deltas as they are
					if (cmd.short_rtt || out_less)
						out_nxt = cmd.d_out;
					if (cmd.short_rtt || in_less)
						in_nxt = cmd.d_in;
					if (cmd.short_rtt) begin
						fin_now = 1'b1;
					end else begin
						trial_nxt = trial_inc;
						fin_now   = (reply_inc >= limits.max_replies) ||
						            (trial_inc >= limits.max_trials);
					end
				end
			end
			default: ;
		endcase
		if (fin_now)
			active_nxt = 1'b0;
	end

	// a run end needs a free result slot, counting what is still in the pipe
	assign pending = res_count + CW'(fin_v_s1) + CW'(fin_v_s2);
	assign room    = pending < CW'(coe_pkg::RES_DEPTH);
	assign cmd_pop = !cmd_empty && (!fin_now || room);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_out_q <= coe_pkg::MIN_INIT;
			min_in_q  <= coe_pkg::MIN_INIT;
			reply_q   <= '0;
			trial_q   <= '0;
			stat_q    <= coe_pkg::STAT_DOWN;
			active_q  <= 1'b0;
			fin_v_s1  <= 1'b0;
			fin_v_s2  <= 1'b0;
		end else begin
			if (cmd_pop) begin
				min_out_q <= out_nxt;
				min_in_q  <= in_nxt;
				reply_q   <= reply_nxt;
				trial_q   <= trial_nxt;
				stat_q    <= stat_nxt;
				active_q  <= active_nxt;
			end
			fin_v_s1 <= cmd_pop && fin_now;
			fin_v_s2 <= fin_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		fin_stat_s1 <= stat_nxt;
		fin_out_s1  <= out_nxt;
		fin_in_s1   <= in_nxt;
		fin_stat_s2 <= fin_stat_s1;
		diff_s2     <= fin_out_s1 - fin_in_s1;
	end

	// halve toward zero: arithmetic shift, plus one for odd negatives
	assign half = {diff_s2[31], diff_s2[31:1]};

	assign res_push         = fin_v_s2;
	assign res_data.status  = fin_stat_s2;
	assign res_data.offset_ms = (fin_stat_s2 == coe_pkg::STAT_GOOD) ?
		half + {24'd0, limits.processing_ms} + {31'd0, diff_s2[31] & diff_s2[0]} :
		32'd0;

endmodule
`default_nettype wire

// ===== hdl/clock_offset_estimator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clock_offset_estimator - peer clock offset from timestamp exchanges
// Top level: configuration registers, front end, command queue, back end
// and result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (push/full): one transaction per item. kind selects start
//   of a run, trial timeout or reply; send_ms/recv_ms/peer_ms carry the
//   timestamps of a reply. A transaction is taken on a clock edge with push
//   high and full low.
//   Result channel (empty/pop): one transaction each time a run ends, with
//   status and offset_ms. The oldest result is shown while empty is low and
//   leaves on an edge with pop high.
//   Config: wr_en/wr_index/wr_data write one of max_replies, max_trials,
//   range_ms and processing_ms, chosen by wr_index. Write only while no
//   transaction is in flight.
// Throughput: one input transaction per cycle while the result queue has room.
//   The front end register, the two-entry command queue and the back end all
//   move one command per cycle; a run end waits for a free result slot.
// Path: a run end reaches the result ports from the edge that accepted the
//   last transaction of the run through the front register, the command
//   queue, the two finish stages and the result queue.
// Reset: arst_n clears the run state (idle, minima at max) and restores the
//   register defaults 10/20/20/5; both queues come up empty.
// Stall: if pop stays low the four-entry result queue fills, the back end
//   holds any command that would end a run, the command queue fills and
//   full rises. Nothing is dropped.
// ----------------------------------------------------------------------------
module clock_offset_estimator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         kind,
	input  wire logic [26:0]        send_ms,
	input  wire logic [26:0]        recv_ms,
	input  wire logic [31:0]        peer_ms,
	// result channel
	output logic                    empty,
	input  wire logic               pop,
	output logic [1:0]              status,
	output logic signed [31:0]      offset_ms,
	// configuration
	input  wire logic               wr_en,
	input  wire logic [1:0]         wr_index,
	input  wire logic [15:0]        wr_data
);

	// config registers
	logic [7:0]   max_replies_q;
	logic [7:0]   max_trials_q;
	logic [15:0]  range_ms_q;
	logic [7:0]   proc_ms_q;

	coe_pkg::limits_t  limits;
	coe_pkg::cmd_t     fe_cmd;
	coe_pkg::cmd_t     q_cmd;
	coe_pkg::result_t  be_res;
	coe_pkg::result_t  out_res;
	logic              fe_push;
	logic              q_full;
	logic              q_empty;
	logic              be_pop;
	logic              res_push;
	logic [$clog2(coe_pkg::RES_DEPTH):0] res_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_replies_q <= coe_pkg::MAX_REPLIES_RST;
			max_trials_q  <= coe_pkg::MAX_TRIALS_RST;
			range_ms_q    <= coe_pkg::RANGE_MS_RST;
			proc_ms_q     <= coe_pkg::PROC_MS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				coe_pkg::REG_MAX_REPLIES: max_replies_q <= wr_data[7:0];
				coe_pkg::REG_MAX_TRIALS:  max_trials_q  <= wr_data[7:0];
				coe_pkg::REG_RANGE_MS:    range_ms_q    <= wr_data;
				coe_pkg::REG_PROC_MS:     proc_ms_q     <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign limits.max_replies   = max_replies_q;
	assign limits.max_trials    = max_trials_q;
	assign limits.processing_ms = proc_ms_q;

	// front: classify and fold
	coe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.send_ms  (send_ms),
		.recv_ms  (recv_ms),
		.peer_ms  (peer_ms),
		.range_ms (range_ms_q),
		.cmd_push (fe_push),
		.cmd_data (fe_cmd),
		.cmd_full (q_full)
	);

	// decoupling queue
	coe_cmd_queue u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fe_push),
		.push_data (fe_cmd),
		.full      (q_full),
		.pop       (be_pop),
		.pop_data  (q_cmd),
		.empty     (q_empty)
	);

	// back: run state, minima, offset
	coe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.limits    (limits),
		.cmd       (q_cmd),
		.cmd_empty (q_empty),
		.cmd_pop   (be_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res_data  (be_res)
	);

	// result queue; space is reserved by the back end
	coe_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (be_res),
		.pop       (pop),
		.pop_data  (out_res),
		.empty     (empty),
		.count     (res_count)
	);

	assign status    = out_res.status;
	assign offset_ms = $signed(out_res.offset_ms);

endmodule
`default_nettype wire

// ===== hdl/coe_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coe_checker - port-level checks of the clock offset estimator
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module coe_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic [1:0]         status,
	input wire logic signed [31:0] offset_ms
);

	// result queue comes out of reset empty
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result shown right after reset");

	// a waiting result holds until it is popped
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(offset_ms)))
		else $error("waiting result changed or vanished");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status != 2'd3))
		else $error("undefined status code");

	// offset is zero unless the measurement is good
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != coe_pkg::STAT_GOOD) |-> (offset_ms == 32'sd0))
		else $error("offset given for a failed run");

endmodule

bind clock_offset_estimator coe_checker u_coe_checker (.*);
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking testbench of the clock offset estimator
// Walks a table of corner-case items, then runs randomized measurement runs
// over several register settings. Every accepted input transaction goes
// through a local estimator; every run-end result that leaves the block is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import coe_pkg::*;

	// kind 3 has no meaning in the block and must be dropped silently
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int RAND_ITEMS    = 500;     // random transactions
	localparam int PHASE_ITEMS   = 100;     // random transactions per register setting
	localparam int DRAIN_TAIL    = 8;       // front reg + cmd queue + finish stages, plus slack
	localparam int LIMIT_CYCLES  = 500000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [26:0] send;
		logic [26:0] recv;
		logic [31:0] peer;
	} item_t;

	// one row of the directed table: either a register setting or an item
	typedef struct {
		bit          cfg;
		logic [7:0]  c_rep;
		logic [7:0]  c_trl;
		logic [15:0] c_rng;
		logic [7:0]  c_prc;
		item_t       it;
		bit          known;     // expected result typed into the table
		bit          k_res;
		result_t     k_exp;
	} step_row_t;

	// ------------------------------------------------------------------------
	// clock, reset, DUT
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	always #2 clk = ~clk;

	logic               arst_n   = 1'b0;
	logic               push     = 1'b0;
	logic               full;
	logic [1:0]         kind     = KIND_START;
	logic [26:0]        send_ms  = '0;
	logic [26:0]        recv_ms  = '0;
	logic [31:0]        peer_ms  = '0;
	logic               empty;
	logic               pop      = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] offset_ms;
	logic               wr_en    = 1'b0;
	logic [1:0]         wr_index = REG_MAX_REPLIES;
	logic [15:0]        wr_data  = '0;

	clock_offset_estimator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.send_ms   (send_ms),
		.recv_ms   (recv_ms),
		.peer_ms   (peer_ms),
		.empty     (empty),
		.pop       (pop),
		.status    (status),
		.offset_ms (offset_ms),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	// ------------------------------------------------------------------------
	// local estimator: registers and run state mirrored at the block's widths
	// ------------------------------------------------------------------------
	logic [7:0]  lim_replies  = MAX_REPLIES_RST;
	logic [7:0]  lim_trials   = MAX_TRIALS_RST;
	logic [15:0] short_rtt_ms = RANGE_MS_RST;
	logic [7:0]  proc_corr_ms = PROC_MS_RST;

	logic [31:0] best_out   = MIN_INIT;     // smallest outbound delta so far
	logic [31:0] best_in    = MIN_INIT;     // smallest inbound delta so far
	logic [7:0]  n_replies  = '0;
	logic [7:0]  n_trials   = '0;
	logic [1:0]  cur_status = STAT_DOWN;
	bit          in_run     = 1'b0;

	result_t run_ends_due[$];   // run-end results predicted but not yet popped

	int  n_items   = 0;
	int  n_checked = 0;
	int  n_err     = 0;
	int  n_phases  = 0;
	int  n_cycles  = 0;
	bit  no_idle   = 1'b0;     // both sides run flat out while set

	// Wrap a signed 32-bit delta once into the +/- 12 hour window.
	function automatic logic [31:0] fold_half_day(input logic [31:0] raw);
		longint d;
		d = longint'($signed(raw));
		if (d < longint'(FOLD_LO))
			d = d + longint'(DAY_MS);
		else if (d > longint'(FOLD_HI))
			d = d - longint'(DAY_MS);
		return d[31:0];
	endfunction

	// End of run: status, and the halved min difference (toward zero) plus
	// the processing correction when the measurement is good.
	function automatic result_t close_run();
		result_t r;
		int      diff;
		r.status    = cur_status;
		r.offset_ms = '0;
		if (cur_status == STAT_GOOD) begin
			diff = best_out - best_in;
			r.offset_ms = 32'(diff / 2) + 32'(proc_corr_ms);
		end
		in_run = 1'b0;
		return r;
	endfunction

	// Advance the estimate by one accepted transaction; returns 1 when the
	// transaction ends the run, with the result in r.
	function automatic bit advance_estimate(input item_t it, output result_t r);
		longint      rtt;
		logic [31:0] d_out;
		logic [31:0] d_in;
		r = '0;
		if (it.kind == KIND_START) begin
			// also drops a run in progress without a result
			best_out   = MIN_INIT;
			best_in    = MIN_INIT;
			n_replies  = '0;
			n_trials   = '0;
			cur_status = STAT_DOWN;
			in_run     = 1'b1;
			return 1'b0;
		end
		if (it.kind == KIND_UNUSED || !in_run)
			return 1'b0;
		if (it.kind == KIND_REPLY) begin
			rtt = longint'(it.recv) - longint'(it.send);
			// negative round trip: reply skipped, still one trial
			if (rtt >= 0) begin
				n_replies = n_replies + 8'd1;
				if (it.peer[31]) begin
					cur_status = STAT_NONSTD;
					r = close_run();
					return 1'b1;
				end
				cur_status = STAT_GOOD;
				d_out = fold_half_day(it.peer - 32'(it.send));
				d_in  = fold_half_day(32'(it.recv) - it.peer);
				if ($signed(d_out) < $signed(best_out))
					best_out = d_out;
				if ($signed(d_in) < $signed(best_in))
					best_in = d_in;
				// short round trip: this reply alone decides the offset
				if (rtt < longint'(short_rtt_ms)) begin
					best_out = d_out;
					best_in  = d_in;
					r = close_run();
					return 1'b1;
				end
			end
		end
		n_trials = n_trials + 8'd1;
		if (n_replies >= lim_replies || n_trials >= lim_trials) begin
			r = close_run();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------------

	// Present one item, hold it until the block takes the transaction, then
	// predict. All calls start right after a rising edge.
	task automatic drive_item(input item_t it, input bit known, input bit k_res,
			input result_t k_exp);
		result_t r;
		bit      has;
		push    <= 1'b1;
		kind    <= it.kind;
		send_ms <= it.send;
		recv_ms <= it.recv;
		peer_ms <= it.peer;
		@(posedge clk);
		while (full)
			@(posedge clk);
		has = advance_estimate(it, r);
		if (known) begin
			has = k_res;
			r   = k_exp;
		end
		if (has)
			run_ends_due.push_back(r);
		n_items++;
		// sender gaps at random, with push low; otherwise push stays high
		// into the next item
		while (!no_idle && $urandom_range(99) < 37) begin
			push <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop sending and wait for every predicted result, plus a tail for
	// transactions still in flight that end no run.
	task automatic drain_results(input int tail);
		push <= 1'b0;
		@(posedge clk);
		while (run_ends_due.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// Write all four registers back to back while the block is idle.
	task automatic load_config(input logic [7:0] rep, input logic [7:0] trl,
			input logic [15:0] rng, input logic [7:0] prc);
		logic [1:0]  idx [4];
		logic [15:0] val [4];
		idx = '{REG_MAX_REPLIES, REG_MAX_TRIALS, REG_RANGE_MS, REG_PROC_MS};
		val = '{{8'd0, rep}, {8'd0, trl}, rng, {8'd0, prc}};
		drain_results(DRAIN_TAIL);
		for (int i = 0; i < 4; i++) begin
			wr_en    <= 1'b1;
			wr_index <= idx[i];
			wr_data  <= val[i];
			@(posedge clk);
		end
		wr_en <= 1'b0;
		lim_replies  = rep;
		lim_trials   = trl;
		short_rtt_ms = rng;
		proc_corr_ms = prc;
		n_phases++;
	endtask

	// Random item, mostly replies shaped like real exchanges around the
	// current short-trip limit, with some garbage mixed in.
	function automatic item_t rand_item();
		item_t       it;
		int unsigned sel;
		int unsigned rtt;
		longint      off;
		longint      pk;
		sel = $urandom_range(99);
		it.kind = (sel < 7)  ? KIND_START :
		          (sel < 35) ? KIND_TIMEOUT :
		          (sel < 97) ? KIND_REPLY : KIND_UNUSED;
		it.send = 27'($urandom_range(5000, 86399999));
		sel = $urandom_range(99);
		if (sel < 25) begin
			rtt = $urandom_range(32'(short_rtt_ms) + 3);
			it.recv = it.send + 27'(rtt);
		end else if (sel < 80) begin
			rtt = $urandom_range(3000);
			it.recv = it.send + 27'(rtt);
		end else if (sel < 90) begin
			// reply stamped before its request
			rtt = 0;
			it.recv = it.send - 27'($urandom_range(1, 5000));
		end else begin
			rtt = 0;
			it.send = 27'($urandom());
			it.recv = 27'($urandom());
		end
		sel = $urandom_range(99);
		if (sel < 4) begin
			it.peer = {1'b1, 31'($urandom())};
		end else if (sel < 10) begin
			it.peer = $urandom();
		end else begin
			if (sel < 85)
				off = longint'($urandom_range(100000)) - 50000;
			else
				off = longint'($urandom_range(86399999)) - 43200000;
			pk = longint'(it.send) + longint'(rtt / 2) + off;
			// wrap across midnight
			pk = pk % 86400000;
			if (pk < 0)
				pk = pk + 86400000;
			it.peer = pk[31:0];
		end
		return it;
	endfunction

	// ------------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------------
	step_row_t dir_rows[$];

	task automatic add_check(input logic [1:0] k, input logic [26:0] s,
			input logic [26:0] r, input logic [31:0] p);
		step_row_t row;
		row = '{default: 0};
		row.it = '{k, s, r, p};
		dir_rows.push_back(row);
	endtask

	task automatic add_known(input logic [1:0] k, input logic [26:0] s,
			input logic [26:0] r, input logic [31:0] p, input bit res,
			input logic [1:0] st, input logic [31:0] off);
		step_row_t row;
		row = '{default: 0};
		row.it    = '{k, s, r, p};
		row.known = 1'b1;
		row.k_res = res;
		row.k_exp = '{st, off};
		dir_rows.push_back(row);
	endtask

	task automatic add_cfg(input logic [7:0] rep, input logic [7:0] trl,
			input logic [15:0] rng, input logic [7:0] prc);
		step_row_t row;
		row = '{default: 0};
		row.cfg   = 1'b1;
		row.c_rep = rep;
		row.c_trl = trl;
		row.c_rng = rng;
		row.c_prc = prc;
		dir_rows.push_back(row);
	endtask

	// ------------------------------------------------------------------------
	// result side: random pop with occasional long stalls, and the checker
	// ------------------------------------------------------------------------
	int      rx_hold = 0;
	result_t want;

	task automatic report_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		n_err++;
		if (n_err <= 10)
			$display("mismatch @%0t %s: expected %0d (0x%08h) got %0d (0x%08h)",
				$realtime, what, $signed(exp_v), exp_v, $signed(act_v), act_v);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			// values sampled here are the ones present at this edge
			if (pop && !empty) begin
				if (run_ends_due.size() == 0) begin
					report_mismatch("result with no run end pending", '0, {30'd0, status});
				end else begin
					want = run_ends_due.pop_front();
					n_checked++;
					if (status !== want.status)
						report_mismatch("status", {30'd0, want.status}, {30'd0, status});
					if (offset_ms !== want.offset_ms)
						report_mismatch("offset_ms", want.offset_ms, offset_ms);
				end
			end
			if (rx_hold != 0) begin
				pop     <= 1'b0;
				rx_hold <= rx_hold - 1;
			end else if (no_idle) begin
				pop <= 1'b1;
			end else begin
				// long stall now and then lets the result queue back up to full
				if ($urandom_range(199) == 0)
					rx_hold <= $urandom_range(10, 40);
				pop <= ($urandom_range(99) >= 37);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= LIMIT_CYCLES) begin
			$display("watchdog expired after %0d cycles, %0d results outstanding",
				n_cycles, run_ends_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		item_t it;
		int    used;
		int    ph;
		int    next_switch;

		// corner cases, register defaults 10/20/20/5 at first
		add_known(KIND_REPLY, 0, 100, 50, 0, STAT_DOWN, 0);        // reply while idle
		add_known(KIND_TIMEOUT, 0, 0, 0, 0, STAT_DOWN, 0);         // timeout while idle
		add_known(KIND_UNUSED, 27'h7ffffff, 27'h7ffffff, 32'hffffffff, 0, STAT_DOWN, 0);
		add_known(KIND_START, 0, 0, 0, 0, STAT_DOWN, 0);
		add_known(KIND_REPLY, 1000, 1010, 1005, 1, STAT_GOOD, 5); // short trip, equal deltas
		add_known(KIND_START, 0, 0, 0, 0, STAT_DOWN, 0);
		add_known(KIND_REPLY, 0, 100, 32'h80000000, 1, STAT_NONSTD, 0); // non-standard time
		add_known(KIND_START, 0, 0, 0, 0, STAT_DOWN, 0);
		add_known(KIND_REPLY, 500, 100, 300, 0, STAT_DOWN, 0);     // negative round trip
		add_known(KIND_START, 0, 0, 0, 0, STAT_DOWN, 0);           // restart mid run
		add_check(KIND_REPLY, 0, 27'h7ffffff, 32'h7fffffff);       // field extremes, both folds
		add_check(KIND_REPLY, 27'h7ffffff, 27'h7ffffff, 0);        // zero round trip ends run
		// trial limit of zero
		add_cfg(10, 0, 20, 5);
		add_known(KIND_START, 0, 0, 0, 0, STAT_DOWN, 0);
		add_known(KIND_TIMEOUT, 0, 0, 0, 1, STAT_DOWN, 0);
		// reply limit of zero
		add_cfg(0, 255, 20, 5);
		add_known(KIND_START, 0, 0, 0, 0, STAT_DOWN, 0);
		add_known(KIND_REPLY, 0, 1000, 500, 1, STAT_GOOD, 5);
		// range 0 never short; midnight wrap of the peer time; max correction
		add_cfg(3, 255, 0, 255);
		add_known(KIND_START, 0, 0, 0, 0, STAT_DOWN, 0);
		add_check(KIND_REPLY, 100, 100, 100);
		add_check(KIND_REPLY, 86399999, 86399999, 0);
		add_check(KIND_REPLY, 0, 1000, 600);
		// widest range; odd negative difference halves toward zero
		add_cfg(10, 20, 65535, 0);
		add_known(KIND_START, 0, 0, 0, 0, STAT_DOWN, 0);
		add_check(KIND_REPLY, 0, 65534, 70000);
		add_known(KIND_START, 0, 0, 0, 0, STAT_DOWN, 0);
		add_check(KIND_REPLY, 0, 11, 2);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg)
				load_config(dir_rows[i].c_rep, dir_rows[i].c_trl,
					dir_rows[i].c_rng, dir_rows[i].c_prc);
			else
				drive_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].k_res,
					dir_rows[i].k_exp);
		end

		// random runs, one register setting per phase
		used        = 0;
		ph          = 0;
		next_switch = 0;
		while (used < RAND_ITEMS) begin
			if (used >= next_switch) begin
				case (ph % 5)
					0: load_config(MAX_REPLIES_RST, MAX_TRIALS_RST, RANGE_MS_RST, PROC_MS_RST);
					1: load_config(8'd255, 8'd255, 16'hffff, 8'd255);
					2: load_config(8'd1, 8'd1, 16'd0, 8'd0);
					3: load_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
						16'($urandom_range(65535)), 8'($urandom_range(255)));
					default: load_config(8'd3, 8'd8, 16'($urandom_range(200)),
						8'($urandom_range(255)));
				endcase
				// one whole phase with no idling on either side
				no_idle     = (ph == 3);
				ph++;
				next_switch = used + PHASE_ITEMS;
			end
			it = rand_item();
			drive_item(it, 1'b0, 1'b0, '0);
			used++;
			// sender holds off now and then until every result is out
			if ($urandom_range(79) == 0)
				drain_results(0);
		end

		drain_results(4 * DRAIN_TAIL);
		$display("%0d input transactions, %0d run-end results checked, %0d register settings",
			n_items, n_checked, n_phases);
		$display("covered corner rows, idle and restart cases, limits at 0/1/255, stalls");
		if (n_err == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", n_err);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
